// ----- rtl/core/wjps_pkg.sv -----
// wjps_pkg: shared constants and controller/datapath command types
// for the weighted jaccard pair similarity block; no dependencies
package wjps_pkg;

    // default configuration of the block
    localparam int MAX_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 15;

    // fixed field widths
    localparam int VAL_W     = 16;
    localparam int OUT_CNT_W = 9;
    localparam int SIM_W     = 16;

    localparam logic [SIM_W-1:0] SIM_MAX = {SIM_W{1'b1}};

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // row transfer this cycle
        logic step;     // one divider iteration
        logic load;     // move quotient into output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free; // output register empty or being drained
    } t_dp_stat;

endpackage

// ----- rtl/core/wjps_if.sv -----
// wjps_row_if / wjps_res_if: valid/ready channels of the block
// depends on wjps_pkg for field widths
interface wjps_row_if;
    logic                          valid;
    logic                          ready;
    logic [wjps_pkg::VAL_W-1:0]    value_a;
    logic [wjps_pkg::VAL_W-1:0]    value_b;
    logic                          last_row;

    modport source (output valid, value_a, value_b, last_row, input ready);
    modport sink   (input valid, value_a, value_b, last_row, output ready);
endinterface

interface wjps_res_if;
    logic                            valid;
    logic                            ready;
    logic [wjps_pkg::OUT_CNT_W-1:0]  match_total;
    logic [wjps_pkg::OUT_CNT_W-1:0]  union_total;
    logic [wjps_pkg::SIM_W-1:0]      similarity;
    logic                            divide_by_zero;

    modport source (output valid, match_total, union_total, similarity, divide_by_zero,
                    input ready);
    modport sink   (input valid, match_total, union_total, similarity, divide_by_zero,
                    output ready);
endinterface

// ----- rtl/core/wjps_ctrl.sv -----
// wjps_ctrl: sequencer for row accumulation, divider iterations and result load
// depends on wjps_pkg (command and status structs)
module wjps_ctrl #(
    parameter int NUM_W = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_row_valid,
    input  logic                i_row_last,
    input  wjps_pkg::t_dp_stat  i_stat,
    output logic                o_row_ready,
    output wjps_pkg::t_dp_cmd   o_cmd
);

    localparam int ITER_W = $clog2(NUM_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NUM_W - 1);

    localparam logic [1:0] S_ACCUM = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter,  n_iter;
    logic              accept;

    assign accept = i_row_valid && o_row_ready;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        o_row_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_ACCUM: begin
                // no row transfer while reset is held
                o_row_ready  = i_rst_n;
                o_cmd.accept = accept;
                if (accept && i_row_last) begin
                    n_state = S_DIV;
                    n_iter  = ITER_LAST;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_iter == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

// ----- rtl/core/wjps_dp.sv -----
// wjps_dp: saturating match/union counters, restoring divider, output register
// depends on wjps_pkg (widths, command and status structs)
module wjps_dp #(
    parameter int MAX_ROWS  = wjps_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = wjps_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wjps_pkg::t_dp_cmd                i_cmd,
    input  logic [wjps_pkg::VAL_W-1:0]       i_value_a,
    input  logic [wjps_pkg::VAL_W-1:0]       i_value_b,
    input  logic                             i_last_row,
    input  logic                             i_out_ready,
    output wjps_pkg::t_dp_stat               o_stat,
    output logic                             o_out_valid,
    output logic [wjps_pkg::OUT_CNT_W-1:0]   o_match_total,
    output logic [wjps_pkg::OUT_CNT_W-1:0]   o_union_total,
    output logic [wjps_pkg::SIM_W-1:0]       o_similarity,
    output logic                             o_divide_by_zero
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int NUM_W = CNT_W + FRAC_BITS;
    localparam int OCW   = wjps_pkg::OUT_CNT_W;
    localparam int SW    = wjps_pkg::SIM_W;
    localparam logic [CNT_W:0] MAX_EXT = (CNT_W+1)'(MAX_ROWS);

    logic [CNT_W-1:0] r_match, r_union;
    logic [CNT_W-1:0] r_div_match, r_div_union;
    logic [CNT_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic             r_out_valid;

    logic             eq;
    logic [CNT_W:0]   inc, match_sum, union_sum;
    logic [CNT_W-1:0] match_fin, union_fin;
    logic [CNT_W:0]   shifted;
    logic [CNT_W+1:0] trial;
    logic             ge;
    logic [NUM_W+SW-1:0] quo_ext;
    logic [CNT_W+OCW-1:0] match_ext, union_ext;
    logic [SW-1:0]    sim_sat;

    // saturating counter update for this row
    always_comb begin
        eq = (i_value_a == i_value_b);
        if (eq) begin
            inc = (CNT_W+1)'(1);
        end else begin
            inc = (CNT_W+1)'(i_value_a != '0) + (CNT_W+1)'(i_value_b != '0);
        end
        match_sum = {1'b0, r_match} + (CNT_W+1)'(eq);
        union_sum = {1'b0, r_union} + inc;
        match_fin = (match_sum > MAX_EXT) ? MAX_EXT[CNT_W-1:0] : match_sum[CNT_W-1:0];
        union_fin = (union_sum > MAX_EXT) ? MAX_EXT[CNT_W-1:0] : union_sum[CNT_W-1:0];
    end

    // one restoring division step
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div_union};
        ge      = !trial[CNT_W+1];
    end

    always_comb begin
        quo_ext   = {{SW{1'b0}}, r_quo};
        sim_sat   = (|quo_ext[NUM_W+SW-1:SW]) ? wjps_pkg::SIM_MAX : quo_ext[SW-1:0];
        match_ext = {{OCW{1'b0}}, r_div_match};
        union_ext = {{OCW{1'b0}}, r_div_union};
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= '0;
            r_union     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_last_row) begin
                    r_match <= '0;
                    r_union <= '0;
                end else begin
                    r_match <= match_fin;
                    r_union <= union_fin;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider operands and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last_row) begin
            r_div_match <= match_fin;
            r_div_union <= union_fin;
            r_rem       <= '0;
            r_quo       <= {match_fin, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.step) begin
            r_rem <= ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
        if (i_cmd.load) begin
            o_match_total    <= match_ext[OCW-1:0];
            o_union_total    <= union_ext[OCW-1:0];
            o_divide_by_zero <= (r_div_union == '0);
            o_similarity     <= (r_div_union == '0) ? '0 : sim_sat;
        end
    end

endmodule

// ----- rtl/core/weighted_jaccard_pair_similarity.sv -----
// weighted_jaccard_pair_similarity: top level, joins controller and datapath
// depends on wjps_pkg, wjps_row_if, wjps_res_if, wjps_ctrl, wjps_dp
//
// Rows of a column pair arrive one per cycle on i_row while i_row.ready is
// high, each a value from both columns and a last-row flag. Equal values
// (zeros included) add one to both the match and the union count; unequal
// values add one to the union count per nonzero value; both counts saturate
// at MAX_ROWS. The last row is counted, the counters clear, and a restoring
// divider forms floor(match * 2^FRAC_BITS / union) one quotient bit per
// cycle. While the bit-serial divider runs and the result is loaded,
// i_row.ready stays low. The result sits in an output register on o_res, so
// rows of the next pair keep flowing while it waits to be taken; after a
// second last row, i_row.ready stays low until the first result transfers.
// similarity saturates at 65535, counts are given in 9 bits, and a zero
// union gives similarity 0 with divide_by_zero set.
module weighted_jaccard_pair_similarity #(
    parameter int MAX_ROWS  = wjps_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = wjps_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wjps_row_if.sink    i_row,
    wjps_res_if.source  o_res
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int NUM_W = CNT_W + FRAC_BITS;

    wjps_pkg::t_dp_cmd  cmd;
    wjps_pkg::t_dp_stat stat;
    logic               row_ready;

    // row channel ready comes from the sequencer
    assign i_row.ready = row_ready;

    wjps_ctrl #(
        .NUM_W (NUM_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_valid (i_row.valid),
        .i_row_last  (i_row.last_row),
        .i_stat      (stat),
        .o_row_ready (row_ready),
        .o_cmd       (cmd)
    );

    // counters, divider and result register
    wjps_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_value_a        (i_row.value_a),
        .i_value_b        (i_row.value_b),
        .i_last_row       (i_row.last_row),
        .i_out_ready      (o_res.ready),
        .o_stat           (stat),
        .o_out_valid      (o_res.valid),
        .o_match_total    (o_res.match_total),
        .o_union_total    (o_res.union_total),
        .o_similarity     (o_res.similarity),
        .o_divide_by_zero (o_res.divide_by_zero)
    );

endmodule

// ----- rtl/core/wjps_chk.sv -----
// wjps_chk: port-level assertions on the result channel, bound to the top level
// depends on wjps_pkg and weighted_jaccard_pair_similarity
module wjps_chk #(
    parameter int MAX_ROWS = wjps_pkg::MAX_ROWS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [wjps_pkg::OUT_CNT_W-1:0]  i_match_total,
    input logic [wjps_pkg::OUT_CNT_W-1:0]  i_union_total,
    input logic [wjps_pkg::SIM_W-1:0]      i_similarity,
    input logic                            i_divide_by_zero
);

    localparam logic COUNTS_EXACT = (MAX_ROWS < 512);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transfer");

    // a stalled result keeps its counts and similarity
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_match_total) && $stable(i_union_total) && $stable(i_similarity))
        else $error("result payload changed while stalled");

    // the last row is always counted, so the union is never empty
    a_no_zero_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_divide_by_zero && (!COUNTS_EXACT || i_union_total != '0))
        else $error("empty union reported");

    // matches are a subset of the union
    a_match_le_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && COUNTS_EXACT |-> i_match_total <= i_union_total)
        else $error("match count above union count");

endmodule

bind weighted_jaccard_pair_similarity wjps_chk #(
    .MAX_ROWS (MAX_ROWS)
) u_wjps_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_match_total    (o_res.match_total),
    .i_union_total    (o_res.union_total),
    .i_similarity     (o_res.similarity),
    .i_divide_by_zero (o_res.divide_by_zero)
);
